// File: sv/oid_content_decode_core_macros.svh
// ---------------------------------------------------------------------------
// oid_content_decode_core_macros.svh
// Assertion macros for the object identifier content decoder.
// ---------------------------------------------------------------------------
`ifndef OID_CONTENT_DECODE_CORE_MACROS_SVH
`define OID_CONTENT_DECODE_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define OCD_ASSERT_NOW(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define OCD_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define OCD_ASSERT_NOW(name, expr, msg)
`define OCD_ASSERT_IMPL(name, ante, cons, msg)
`endif

`endif

// File: sv/ocd_pkg.sv
// ---------------------------------------------------------------------------
// ocd_pkg
// Types and constants shared by the object identifier content decoder.
// ---------------------------------------------------------------------------
package ocd_pkg;

  localparam int MAX_CONTENT_BYTES_DEF = 19;
  localparam int ARC_BITS_DEF          = 28;
  localparam int QUEUE_DEPTH_DEF       = 4;

  localparam int ARC_W = 28;
  localparam int NUM_W = 5;
  localparam int STS_W = 3;

  localparam logic [7:0] FIRST_DIV = 8'd40;

  localparam logic [STS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STS_W-1:0] ST_LONG  = 3'd1;
  localparam logic [STS_W-1:0] ST_FIRST = 3'd2;
  localparam logic [STS_W-1:0] ST_OVF   = 3'd3;
  localparam logic [STS_W-1:0] ST_TRUNC = 3'd4;

  typedef struct packed {
    logic [7:0] content_byte;
    logic       final_byte;
  } item_t;

  typedef struct packed {
    logic [ARC_W-1:0] arc_value;
    logic [NUM_W-1:0] arc_number;
    logic [STS_W-1:0] status;
    logic             end_of_object;
    logic             last_of_item;
  } arc_t;

  typedef struct packed {
    logic             pair;
    logic [1:0]       first_arc;
    logic [ARC_W-1:0] value;
    logic [NUM_W-1:0] number;
    logic [STS_W-1:0] status;
    logic             eoo;
  } cmd_t;

endpackage

// File: sv/ocd_front.sv
// ---------------------------------------------------------------------------
// ocd_front
// Tracks object state per content byte and issues result commands.
// ---------------------------------------------------------------------------
module ocd_front import ocd_pkg::*; #(
  parameter int MAX_CONTENT_BYTES = MAX_CONTENT_BYTES_DEF,
  parameter int ARC_BITS          = ARC_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  accept,
  input  item_t item,
  output logic  push,
  output cmd_t  cmd
);

  localparam int BW = $clog2(MAX_CONTENT_BYTES + 1);

  logic [ARC_BITS-1:0] partial_arc, partial_arc_next, shifted;
  logic [BW-1:0]       bytes_seen, bytes_seen_next;
  logic [NUM_W-1:0]    arcs_emitted, arcs_emitted_next;
  logic                dropping, dropping_next;
  logic                err;
  logic [STS_W-1:0]    err_status;
  logic [1:0]          a0;
  logic [7:0]          a1;
  logic                fin;

  assign fin     = item.final_byte;
  assign shifted = {partial_arc[ARC_BITS-8:0], item.content_byte[6:0]};

  always_comb begin
    if (item.content_byte >= 8'(2 * FIRST_DIV)) begin
      a0 = 2'd2;
      a1 = item.content_byte - 8'(2 * FIRST_DIV);
    end else if (item.content_byte >= FIRST_DIV) begin
      a0 = 2'd1;
      a1 = item.content_byte - FIRST_DIV;
    end else begin
      a0 = 2'd0;
      a1 = item.content_byte;
    end
  end

  always_comb begin
    partial_arc_next  = partial_arc;
    bytes_seen_next   = bytes_seen;
    arcs_emitted_next = arcs_emitted;
    dropping_next     = dropping;
    err               = 1'b0;
    err_status        = ST_OK;
    push              = 1'b0;
    cmd               = '0;
    if (accept) begin
      if (dropping) begin
        if (fin) begin
          partial_arc_next  = '0;
          bytes_seen_next   = '0;
          arcs_emitted_next = '0;
          dropping_next     = 1'b0;
        end
      end else if (bytes_seen >= BW'(MAX_CONTENT_BYTES)) begin
        err        = 1'b1;
        err_status = ST_LONG;
      end else if (bytes_seen == '0) begin
        bytes_seen_next = BW'(1);
        if (item.content_byte >= 8'(3 * FIRST_DIV)) begin
          err        = 1'b1;
          err_status = ST_FIRST;
        end else begin
          push              = 1'b1;
          cmd.pair          = 1'b1;
          cmd.first_arc     = a0;
          cmd.value         = ARC_W'(a1);
          cmd.number        = NUM_W'(1);
          cmd.status        = ST_OK;
          cmd.eoo           = fin;
          arcs_emitted_next = NUM_W'(2);
          if (fin) begin
            partial_arc_next  = '0;
            bytes_seen_next   = '0;
            arcs_emitted_next = '0;
          end
        end
      end else begin
        bytes_seen_next = bytes_seen + BW'(1);
        if (|partial_arc[ARC_BITS-1:ARC_BITS-7]) begin
          err        = 1'b1;
          err_status = ST_OVF;
        end else if (item.content_byte[7]) begin
          partial_arc_next = shifted;
          if (fin) begin
            err        = 1'b1;
            err_status = ST_TRUNC;
          end
        end else begin
          push              = 1'b1;
          cmd.value         = ARC_W'(shifted);
          cmd.number        = arcs_emitted;
          cmd.status        = ST_OK;
          cmd.eoo           = fin;
          arcs_emitted_next = arcs_emitted + NUM_W'(1);
          partial_arc_next  = '0;
          if (fin) begin
            bytes_seen_next   = '0;
            arcs_emitted_next = '0;
          end
        end
      end
      if (err) begin
        push       = 1'b1;
        cmd        = '0;
        cmd.number = arcs_emitted;
        cmd.status = err_status;
        cmd.eoo    = 1'b1;
        if (fin) begin
          partial_arc_next  = '0;
          bytes_seen_next   = '0;
          arcs_emitted_next = '0;
          dropping_next     = 1'b0;
        end else begin
          dropping_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_arc  <= '0;
      bytes_seen   <= '0;
      arcs_emitted <= '0;
      dropping     <= 1'b0;
    end else begin
      partial_arc  <= partial_arc_next;
      bytes_seen   <= bytes_seen_next;
      arcs_emitted <= arcs_emitted_next;
      dropping     <= dropping_next;
    end
  end

endmodule

// File: sv/ocd_queue.sv
// ---------------------------------------------------------------------------
// ocd_queue
// Short command queue between the front and back parts.
// ---------------------------------------------------------------------------
module ocd_queue import ocd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  input  logic pop,
  output cmd_t head,
  output logic full,
  output logic empty
);

  localparam int AW = $clog2(DEPTH);

  cmd_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;

  assign full  = (count == (AW+1)'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + (AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

endmodule

// File: sv/ocd_back.sv
// ---------------------------------------------------------------------------
// ocd_back
// Expands queued commands into result items behind an output register.
// ---------------------------------------------------------------------------
module ocd_back import ocd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cmd_t head,
  input  logic empty,
  output logic pop,
  output logic arc_valid,
  input  logic arc_ready,
  output arc_t arc
);

  logic load;
  logic phase;
  logic split;

  assign load  = !arc_valid || arc_ready;
  assign split = head.pair && !phase;
  assign pop   = load && !empty && !split;

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      if (split) begin
        arc.arc_value     <= ARC_W'(head.first_arc);
        arc.arc_number    <= '0;
        arc.status        <= ST_OK;
        arc.end_of_object <= 1'b0;
        arc.last_of_item  <= 1'b0;
      end else begin
        arc.arc_value     <= head.value;
        arc.arc_number    <= head.number;
        arc.status        <= head.status;
        arc.end_of_object <= head.eoo;
        arc.last_of_item  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      arc_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (load) begin
      arc_valid <= !empty;
      if (!empty) begin
        phase <= split;
      end
    end
  end

endmodule

// File: sv/oid_content_decode_core.sv
// ---------------------------------------------------------------------------
// oid_content_decode_core: DER object identifier content decoder
// A taken byte's result is written into the command queue, then loaded into the output register.
// Throughput: one byte per cycle while the four-entry command queue has room;
// a first byte yields two results.
// Reset clears the object state, the command queue and the output valid flag.
// ---------------------------------------------------------------------------
`include "oid_content_decode_core_macros.svh"

module oid_content_decode_core import ocd_pkg::*; #(
  parameter int MAX_CONTENT_BYTES = MAX_CONTENT_BYTES_DEF,
  parameter int ARC_BITS          = ARC_BITS_DEF,
  parameter int QUEUE_DEPTH       = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_ready,
  input  item_t item,
  output logic  arc_valid,
  input  logic  arc_ready,
  output arc_t  arc
);

  logic accept;
  logic push;
  cmd_t cmd;
  cmd_t head;
  logic pop;
  logic q_full;
  logic q_empty;

  assign item_ready = !q_full;
  assign accept     = item_valid && item_ready;

  ocd_front #(
    .MAX_CONTENT_BYTES(MAX_CONTENT_BYTES),
    .ARC_BITS(ARC_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .item(item),
    .push(push),
    .cmd(cmd)
  );

  ocd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_data(cmd),
    .pop(pop),
    .head(head),
    .full(q_full),
    .empty(q_empty)
  );

  ocd_back u_back (
    .clk(clk),
    .rst(rst),
    .head(head),
    .empty(q_empty),
    .pop(pop),
    .arc_valid(arc_valid),
    .arc_ready(arc_ready),
    .arc(arc)
  );

  `OCD_ASSERT_NOW(a_queue_flags, !(q_full && q_empty), "queue full and empty at once")
  `OCD_ASSERT_IMPL(a_error_shape, arc_valid && arc.status != ST_OK, arc.end_of_object && arc.last_of_item && arc.arc_value == '0, "error result malformed")
  `OCD_ASSERT_IMPL(a_split_shape, arc_valid && !arc.last_of_item, arc.arc_number == '0 && arc.status == ST_OK && !arc.end_of_object, "leading first arc malformed")

endmodule
